// File: rtl/cbt_pkg.sv
// shared types and constants for the can bit timing calculator
`timescale 1ns / 1ps
`default_nettype none
package cbt_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned QUANTA_N = 9;
    localparam int unsigned RES_W    = 5;
    localparam int unsigned QUO_W    = 11;

    localparam logic [4:0] QUANTA_MAX = 5'd18;
    localparam logic [4:0] SEG2_FLOOR = 5'd2;
    localparam logic [1:0] JUMP_WIDTH = 2'd2;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_BAD_RATE      = 2'd1,
        ST_NO_QUANTA     = 2'd2,
        ST_BAD_PRESCALER = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] clock_hz;
        logic [31:0] bit_rate;
    } req_word_t;

    typedef struct packed {
        logic [24:0] timing_word;
        logic [1:0]  status;
    } rsp_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]                n;
        logic [DATA_W-1:0]                d;
        logic [DATA_W-1:0]                rem;
        logic [QUANTA_N-1:0][RES_W-1:0]   res;
        logic [QUANTA_N-1:0][QUO_W-1:0]   quo;
        logic [QUANTA_N-1:0]              ovf;
    } stage_t;

    function automatic logic [4:0] quanta_of(input int unsigned j);
        return QUANTA_MAX - 5'(j);
    endfunction

endpackage
`default_nettype wire

// File: rtl/cbt_cell.sv
// one divider cell: one quotient bit plus residues by each quanta count
`timescale 1ns / 1ps
`default_nettype none
module cbt_cell
    import cbt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   valid_in,
    input  wire stage_t data_in,
    output logic        valid_out,
    output stage_t      data_out
);
    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            qbit;
    logic [RES_W:0]  r2   [QUANTA_N];
    logic [RES_W:0]  rsub [QUANTA_N];

    always_comb
    begin
        data_next   = data_in;
        trial       = {data_in.rem, data_in.n[DATA_W-1]};
        diff        = trial - {1'b0, data_in.d};
        qbit        = (trial >= {1'b0, data_in.d});
        data_next.rem = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        data_next.n   = {data_in.n[DATA_W-2:0], 1'b0};
        for (int j = 0; j < QUANTA_N; j++)
        begin
            r2[j]   = {data_in.res[j], qbit};
            rsub[j] = r2[j] - {1'b0, quanta_of(j)};
            if (r2[j] >= {1'b0, quanta_of(j)})
            begin
                data_next.res[j] = rsub[j][RES_W-1:0];
                data_next.quo[j] = {data_in.quo[j][QUO_W-2:0], 1'b1};
            end
            else
            begin
                data_next.res[j] = r2[j][RES_W-1:0];
                data_next.quo[j] = {data_in.quo[j][QUO_W-2:0], 1'b0};
            end
            data_next.ovf[j] = data_in.ovf[j] | data_in.quo[j][QUO_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule
`default_nettype wire

// File: rtl/cbt_result.sv
// final cell: picks the quanta count, checks limits and packs the word
`timescale 1ns / 1ps
`default_nettype none
module cbt_result
    import cbt_pkg::*;
#(
    parameter int unsigned PRESCALER_LIMIT = 1024
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   valid_in,
    input  wire stage_t data_in,
    output logic        valid_out,
    output rsp_word_t   word_out
);
    logic      valid_reg;
    rsp_word_t word_reg;
    rsp_word_t word_next;
    logic            found;
    logic [4:0]      tq;
    logic [QUO_W-1:0] presc;
    logic            povf;
    logic [4:0]      s2;
    logic [4:0]      s1;
    logic [QUO_W-1:0] presc_m1;

    always_comb
    begin
        found = 1'b0;
        tq    = QUANTA_MAX;
        presc = '0;
        povf  = 1'b0;
        for (int j = QUANTA_N - 1; j >= 0; j--)
        begin
            if (data_in.res[j] == '0)
            begin
                found = 1'b1;
                tq    = quanta_of(j);
                presc = data_in.quo[j];
                povf  = data_in.ovf[j];
            end
        end
        s2 = {3'd0, tq[4:3]};
        if (s2 < SEG2_FLOOR)
        begin
            s2 = SEG2_FLOOR;
        end
        s1       = tq - 5'd1 - s2;
        presc_m1 = presc - QUO_W'(1);
        word_next.timing_word = '0;
        priority if (data_in.d == '0 || data_in.rem != '0)
        begin
            word_next.status = ST_BAD_RATE;
        end
        else if (!found)
        begin
            word_next.status = ST_NO_QUANTA;
        end
        else if (povf || presc == '0 || presc > QUO_W'(PRESCALER_LIMIT))
        begin
            word_next.status = ST_BAD_PRESCALER;
        end
        else
        begin
            word_next.status = ST_OK;
            word_next.timing_word = {1'(JUMP_WIDTH - 2'd1), 1'b0, s2[2:0] - 3'd1,
                                     s1[3:0] - 4'd1, 6'd0, presc_m1[9:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;
endmodule
`default_nettype wire

// File: rtl/can_bit_timing_calc_core.sv
// top level: chain of divider cells followed by the result cell
// stages: 32 divider cells, then one result cell, from accepted word to result word
// throughput: one word per cycle; the whole chain advances unless the output is stalled
// reset: asynchronous, clears all valid flags; the data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module can_bit_timing_calc_core
    import cbt_pkg::*;
#(
    parameter int unsigned PRESCALER_LIMIT = 1024
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word
);
    logic   en;
    logic   v    [DATA_W+1];
    stage_t d    [DATA_W+1];

    assign en        = !rsp_valid || !rsp_stall;
    assign req_stall = !en;

    always_comb
    begin
        d[0]     = '0;
        d[0].n   = req_word.clock_hz;
        d[0].d   = req_word.bit_rate;
        v[0]     = req_valid;
    end

    for (genvar k = 0; k < DATA_W; k++)
    begin : g_cell
        cbt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v[k]),
            .data_in   (d[k]),
            .valid_out (v[k+1]),
            .data_out  (d[k+1])
        );
    end

    cbt_result #(.PRESCALER_LIMIT(PRESCALER_LIMIT)) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (v[DATA_W]),
        .data_in   (d[DATA_W]),
        .valid_out (rsp_valid),
        .word_out  (rsp_word)
    );
endmodule
`default_nettype wire

// File: rtl/cbt_checker.sv
// port-level assertions for the can bit timing calculator
`timescale 1ns / 1ps
`default_nettype none
module cbt_checker
    import cbt_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_stall,
    input wire logic      rsp_valid,
    input wire logic      rsp_stall,
    input wire rsp_word_t rsp_word
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status != ST_OK |-> rsp_word.timing_word == '0)
        else $error("error word not zero");

    a_ok_jump: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_OK |-> rsp_word.timing_word[24] == 1'b1)
        else $error("jump width field wrong");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled word changed");
endmodule

bind can_bit_timing_calc_core cbt_checker u_cbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
`default_nettype wire

// File: bench/testbench.sv
// self-checking testbench for the can bit timing calculator core
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import cbt_pkg::*;
;

    localparam int LATENCY = 33;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM = 1800;

    class timing_scoreboard;
        rsp_word_t pending[$];
        int n_err;
        int n_checked;
        int n_stat[4];

        function rsp_word_t compute_timing(req_word_t r);
            rsp_word_t p;
            logic [31:0] per_bit;
            logic [31:0] presc;
            logic [4:0] tq;
            logic [4:0] s2;
            logic [4:0] s1;
            bit found;
            p.timing_word = '0;
            p.status = ST_OK;
            found = 0;
            tq = 0;
            if (r.bit_rate == 0 || (r.clock_hz % r.bit_rate) != 0)
            begin
                p.status = ST_BAD_RATE;
            end
            else
            begin
                per_bit = r.clock_hz / r.bit_rate;
                for (int q = 18; q >= 10; q--)
                begin
                    if (!found && (per_bit % q) == 0)
                    begin
                        found = 1;
                        tq = 5'(q);
                    end
                end
                if (!found)
                begin
                    p.status = ST_NO_QUANTA;
                end
                else
                begin
                    presc = per_bit / tq;
                    if (presc == 0 || presc > 1024)
                    begin
                        p.status = ST_BAD_PRESCALER;
                    end
                    else
                    begin
                        s2 = 5'(tq / 8);
                        if (s2 < 2)
                            s2 = 5'd2;
                        s1 = 5'(tq - 1 - s2);
                        p.timing_word[25-1:24] = 1'b1;
                        p.timing_word[22:20] = 3'(s2 - 1);
                        p.timing_word[19:16] = 4'(s1 - 1);
                        p.timing_word[9:0] = 10'(presc - 1);
                    end
                end
            end
            return p;
        endfunction

        function void note_request(req_word_t r);
            rsp_word_t p;
            p = compute_timing(r);
            pending.push_back(p);
            n_stat[p.status]++;
        endfunction

        function void check_result(rsp_word_t got);
            rsp_word_t exp_w;
            n_checked++;
            if (pending.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got.timing_word !== exp_w.timing_word || got.status !== exp_w.status)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: timing exp %h got %h, status exp %0d got %0d",
                             exp_w.timing_word, got.timing_word, exp_w.status, got.status);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_word_t req_word;
    logic rsp_valid;
    logic rsp_stall;
    rsp_word_t rsp_word;

    timing_scoreboard sb;
    bit hold_off;
    bit stim_done;
    bit timed_out;
    int idle_cycles;

    can_bit_timing_calc_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // accepted words
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req_word);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_word);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        int w;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp_stall <= 1'b1;
            end
            else if (rsp_stall)
            begin
                rsp_stall <= 1'b0;
            end
            else if (stim_done || ($urandom_range(3) == 0))
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                w = $urandom_range(12);
                if (w != 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (w) @(negedge clk);
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_word(input logic [31:0] c, input logic [31:0] r, input bit gaps);
        int w;
        w = gaps ? $urandom_range(12) : 0;
        if (w != 0)
        begin
            req_valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word.clock_hz <= c;
        req_word.bit_rate <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] v;
        v = $urandom;
        return v >> $urandom_range(31);
    endfunction

    initial
    begin
        logic [31:0] rate;
        logic [31:0] mult;
        int kind;
        bit gaps;
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        hold_off = 0;
        stim_done = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners
        send_word(32'd8000000, 32'd0, 0);
        send_word(32'd0, 32'd0, 0);
        send_word(32'd8000001, 32'd500000, 0);
        send_word(32'd0, 32'd125000, 0);
        send_word(32'd72000000, 32'd1000000, 0);
        send_word(32'd36000000, 32'd500000, 0);
        send_word(32'd8000000, 32'd125000, 0);
        send_word(32'd18, 32'd1, 0);
        send_word(32'd10, 32'd1, 0);
        send_word(32'd18432, 32'd1, 0);
        send_word(32'd18450, 32'd1, 0);
        send_word(32'd10240, 32'd1, 0);
        send_word(32'd10250, 32'd1, 0);
        send_word(32'd19, 32'd1, 0);
        send_word(32'd9, 32'd1, 0);
        send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 0);
        send_word(32'hFFFFFFFF, 32'd1, 0);
        send_word(32'hFFFFFFFF, 32'd5, 0);
        send_word(32'd13, 32'd1, 0);
        send_word(32'd16, 32'd1, 0);
        send_word(32'h80000000, 32'h80000000, 0);
        send_word(32'hFFFFFFFE, 32'h7FFFFFFF, 0);

        // long receiver hold-off while the sender keeps going
        fork
            begin
                hold_off = 1;
                repeat (120) @(negedge clk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_word($urandom_range(1024 * 18), 32'd1, 0);
            end
        join

        for (int i = 0; i < N_RANDOM; i++)
        begin
            gaps = ((i / 200) % 3) != 2;
            kind = $urandom_range(9);
            if (kind < 6)
            begin
                // well formed: clock is rate times quanta times prescaler
                rate = $urandom_range(1, 1000000) >> $urandom_range(19);
                if (rate == 0)
                    rate = 1;
                mult = $urandom_range(10, 18) * $urandom_range(1, kind == 0 ? 1100 : 1024);
                send_word(rate * mult, rate, gaps);
            end
            else if (kind < 8)
            begin
                rate = rand_word() | 32'd1;
                send_word(rate * $urandom_range(0, 25000), rate, gaps);
            end
            else
            begin
                send_word(rand_word(), rand_word(), gaps);
            end
        end
        req_valid <= 1'b0;
        stim_done = 1;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("checked %0d results: %0d ok, %0d bad rate, %0d no quanta, %0d bad prescaler",
                 sb.n_checked, sb.n_stat[0], sb.n_stat[1], sb.n_stat[2], sb.n_stat[3]);
        $display("mismatches: %0d", sb.n_err);
        if (sb.n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
